// ===== hw/rtl/rks_pkg.sv =====
package rks_pkg;

   localparam int ROW_W   = 32;
   localparam int ROWS_W  = 4 * ROW_W;
   localparam int RC_W    = 5;
   localparam int IDX_W   = 5;
   localparam int RK_W    = 64;

   localparam logic [RC_W-1:0] RC_INIT = 5'd1;

   typedef logic [ROWS_W-1:0] rows_type;
   typedef logic [RC_W-1:0]   rc_type;
   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [RK_W-1:0]   rkey_type;

   typedef struct packed {
      logic     valid;
      rows_type rows;
      rc_type   rc;
   } cell_link_type;

   function automatic rc_type lfsr_next(input rc_type rc);
      return {rc[3:0], rc[4] ^ rc[2]};
   endfunction

   function automatic rkey_type pack_round_key(input rows_type rows);
      return {rows[111:96], rows[79:64], rows[47:32], rows[15:0]};
   endfunction

   function automatic rows_type round_rows(input rows_type rows, input rc_type rc);
      logic [7:0]       a;
      logic [7:0]       b;
      logic [7:0]       c;
      logic [7:0]       d;
      logic [7:0]       t0;
      logic [7:0]       t1;
      logic [ROW_W-1:0] r0;
      logic [ROW_W-1:0] r1;
      logic [ROW_W-1:0] r2;
      logic [ROW_W-1:0] r3;
      logic [ROW_W-1:0] n0;
      logic [ROW_W-1:0] n2;
      a  = rows[7:0];
      b  = rows[39:32];
      c  = rows[71:64];
      d  = rows[103:96];
      // bitsliced s-box on the low column byte
      t0 = c;
      c  = c ^ b;
      b  = ~b;
      t1 = a;
      a  = a & b;
      b  = b | d;
      b  = b ^ t1;
      d  = d ^ t0;
      a  = a ^ d;
      d  = d & b;
      d  = d ^ c;
      c  = c | a;
      c  = c ^ b;
      b  = b ^ t0;
      r0 = {rows[31:8], a};
      r1 = {rows[63:40], b};
      r2 = {rows[95:72], c};
      r3 = {rows[127:104], d};
      // feistel step and round constant
      n0 = {r0[23:0], r0[31:24]} ^ r1 ^ {{(ROW_W-RC_W){1'b0}}, rc};
      n2 = {r2[15:0], r2[31:16]} ^ r3;
      return {r0, n2, r2, n0};
   endfunction

endpackage

// ===== hw/rtl/rks_cell.sv =====
module rks_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rks_pkg::cell_link_type load,
   output rks_pkg::cell_link_type state,
   output rks_pkg::cell_link_type next
);
   import rks_pkg::*;

   logic     valid_ff;
   rows_type rows_ff;
   rc_type   rc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= load.valid;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff <= load.rows;
      rc_ff   <= load.rc;
   end

   assign state.valid = valid_ff;
   assign state.rows  = rows_ff;
   assign state.rc    = rc_ff;

   assign next.valid = valid_ff;
   assign next.rows  = round_rows(rows_ff, rc_ff);
   assign next.rc    = lfsr_next(rc_ff);

endmodule

// ===== hw/rtl/rectangle128_key_schedule_unit.sv =====
// RECTANGLE-128 key schedule. A key is taken when start is high and busy is low; the
// block then puts out ROUNDS+1 round keys, one per cycle with rsp_valid high, round 0
// (the raw key) first, with rsp_last on the final one. The first round key is held in
// the first cell's register, then in the result register. The key travels down a chain
// of ROUNDS+1 cells, one round per cell per cycle; all round keys share the one result
// port, so a new key is taken only once the previous key is in the last cell, while
// its final round key is still being delivered. The receiver cannot stall: every
// round key is on the result ports for exactly one cycle and must be taken then.
module rectangle128_key_schedule_unit #(
   parameter int ROUNDS = 25
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [63:0]              req_key_low,
   input  logic [63:0]              req_key_high,
   output logic                     rsp_valid,
   output rks_pkg::rkey_type        rsp_round_key,
   output rks_pkg::idx_type         rsp_round_index,
   output logic                     rsp_last
);
   import rks_pkg::*;

   cell_link_type cell_load  [0:ROUNDS];
   cell_link_type cell_state [0:ROUNDS];
   cell_link_type cell_next  [0:ROUNDS];

   logic     accept;
   logic     any_busy;
   logic     sel_valid;
   rkey_type sel_key;
   idx_type  sel_idx;

   logic     rsp_valid_ff;
   rkey_type rsp_round_key_ff;
   idx_type  rsp_round_index_ff;
   logic     rsp_last_ff;

   always_comb begin
      any_busy = 1'b0;
      for (int k = 0; k < ROUNDS; k++) begin
         any_busy = any_busy | cell_state[k].valid;
      end
   end

   assign busy   = any_busy;
   assign accept = start & ~any_busy;

   assign cell_load[0].valid = accept;
   assign cell_load[0].rows  = {req_key_high, req_key_low};
   assign cell_load[0].rc    = RC_INIT;

   genvar g;
   generate
      for (g = 0; g <= ROUNDS; g++) begin : g_cell
         if (g > 0) begin : g_link
            assign cell_load[g] = cell_next[g-1];
         end
         rks_cell u_cell (
            .clock (clock),
            .reset (reset),
            .load  (cell_load[g]),
            .state (cell_state[g]),
            .next  (cell_next[g])
         );
      end
   endgenerate

   // only one cell holds a key at a time
   always_comb begin
      sel_valid = 1'b0;
      sel_key   = '0;
      sel_idx   = '0;
      for (int k = 0; k <= ROUNDS; k++) begin
         if (cell_state[k].valid) begin
            sel_valid = 1'b1;
            sel_key   = sel_key | pack_round_key(cell_state[k].rows);
            sel_idx   = sel_idx | IDX_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= sel_valid;
         rsp_last_ff  <= cell_state[ROUNDS].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_round_key_ff   <= sel_key;
      rsp_round_index_ff <= sel_idx;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_round_key   = rsp_round_key_ff;
   assign rsp_round_index = rsp_round_index_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
